>>> hdl/bns_pkg.sv
// Shared types and constants for the binomial noise sampler.
// Used by the coefficient datapath and the top level; no dependencies.
package bns_pkg;

  localparam int WORD_W     = 32;
  localparam int COEF_W     = 3;
  localparam int COEF_NUM   = 8;
  localparam int COEF_VEC_W = COEF_W * COEF_NUM;
  localparam int MODE_W     = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_MBIN3 = 2'd0,  // mask b0&b1, signs b2
    MODE_CBD2  = 2'd1,  // centered binomial, eta 2
    MODE_MBIN4 = 2'd2,  // mask b0&(b1|b2), signs b3
    MODE_RSVD  = 2'd3   // all coefficients zero
  } mode_t;

  localparam mode_t MODE_RESET = MODE_CBD2;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t COEF_ZERO = 3'sd0;
  localparam coef_t COEF_POS  = 3'sd1;
  localparam coef_t COEF_NEG  = -3'sd1;

  // Masked-sign rule of the modified modes.
  function automatic coef_t masked_sign(input logic mask_bit, input logic sign_bit);
    coef_t v;
    if (!mask_bit) begin
      v = COEF_ZERO;
    end else if (sign_bit) begin
      v = COEF_POS;
    end else begin
      v = COEF_NEG;
    end
    return v;
  endfunction

endpackage

>>> hdl/bns_pipe_reg.sv
// One register stage with valid/ready flow control.
// Accepts a new request whenever it is empty or its content leaves this cycle.
module bns_pipe_reg #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         up_valid,
  output logic         up_ready,
  input  logic [W-1:0] up_data,
  output logic         dn_valid,
  input  logic         dn_ready,
  output logic [W-1:0] dn_data
);

  logic         valid_r;
  logic [W-1:0] data_r;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      data_r <= up_data;
    end
  end

endmodule

>>> hdl/bns_coef_core.sv
// Combinational coefficient datapath: one random word to eight coefficients.
// Depends on bns_pkg for the mode codes and coefficient type.
module bns_coef_core import bns_pkg::*; (
  input  mode_t                  mode,
  input  logic [WORD_W-1:0]      word,
  output logic [COEF_VEC_W-1:0]  coefs   // coef_0 in lowest bits .. coef_7
);

  logic [7:0] b0, b1, b2, b3;
  logic [7:0] mask3, mask4;

  assign b0    = word[7:0];
  assign b1    = word[15:8];
  assign b2    = word[23:16];
  assign b3    = word[31:24];
  assign mask3 = b0 & b1;
  assign mask4 = b0 & (b1 | b2);

  for (genvar j = 0; j < COEF_NUM; j++) begin : g_lane
    logic [1:0] pos_cnt, neg_cnt;
    coef_t      cbd_v;
    coef_t      v;

    assign pos_cnt = {1'b0, word[4*j]}   + {1'b0, word[4*j+1]};
    assign neg_cnt = {1'b0, word[4*j+2]} + {1'b0, word[4*j+3]};
    assign cbd_v   = coef_t'({1'b0, pos_cnt}) - coef_t'({1'b0, neg_cnt});

    always_comb begin
      unique case (mode)
        MODE_MBIN3: v = masked_sign(mask3[j], b2[j]);
        MODE_CBD2:  v = cbd_v;
        MODE_MBIN4: v = masked_sign(mask4[j], b3[j]);
        default:    v = COEF_ZERO;
      endcase
    end

    assign coefs[j*COEF_W +: COEF_W] = v;
  end

endmodule

>>> hdl/binomial_noise_sampler.sv
// Binomial noise sampler: each 32-bit random word becomes eight signed coefficients in
// -2..2 (mode 1, centered binomial) or -1..1 (modes 0 and 2, masked sign); mode 3 gives
// zeros. One word is taken every cycle while out_tready is high; there is one input
// register and one result register, with the sampling logic between them. The mode
// register is captured with each word, so change it only while the pipeline is empty.
module binomial_noise_sampler import bns_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [MODE_W-1:0]      cfg_wdata,      // sample_mode
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [WORD_W-1:0]      in_tdata,       // random_word
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [COEF_VEC_W-1:0]  out_tdata       // coef_0 [2:0], coef_1 .. coef_7 [23:21]
);

  localparam int S1_W = MODE_W + WORD_W;

  mode_t                  mode_r;
  logic                   s1_valid, s1_ready;
  logic [S1_W-1:0]        s1_data;
  mode_t                  s1_mode;
  logic [WORD_W-1:0]      s1_word;
  logic [COEF_VEC_W-1:0]  s1_coefs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
    end else if (cfg_we) begin
      mode_r <= mode_t'(cfg_wdata);
    end
  end

  bns_pipe_reg #(.W(S1_W)) u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_tvalid),
    .up_ready (in_tready),
    .up_data  ({mode_r, in_tdata}),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn_data  (s1_data)
  );

  assign s1_mode = mode_t'(s1_data[S1_W-1 -: MODE_W]);
  assign s1_word = s1_data[WORD_W-1:0];

  bns_coef_core u_core (
    .mode  (s1_mode),
    .word  (s1_word),
    .coefs (s1_coefs)
  );

  bns_pipe_reg #(.W(COEF_VEC_W)) u_out_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up_data  (s1_coefs),
    .dn_valid (out_tvalid),
    .dn_ready (out_tready),
    .dn_data  (out_tdata)
  );

`ifndef SYNTHESIS
  // Reserved mode must produce an all-zero result.
  a_rsvd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid && s1_ready && s1_mode == MODE_RSVD |=> out_tdata == '0)
    else $error("reserved mode gave nonzero coefficients");

  for (genvar j = 0; j < COEF_NUM; j++) begin : g_chk
    // Masked-sign modes never reach magnitude two.
    a_small: assert property (@(posedge clk) disable iff (!rst_n)
      s1_valid && s1_ready && s1_mode != MODE_CBD2
      |=> out_tdata[j*COEF_W +: COEF_W] != 3'b010
          && out_tdata[j*COEF_W +: COEF_W] != 3'b110)
      else $error("masked-sign coefficient out of -1..1");
    // No mode gives 3, -3 or -4.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid |-> out_tdata[j*COEF_W +: COEF_W] != 3'b011
                  && out_tdata[j*COEF_W +: COEF_W] != 3'b101
                  && out_tdata[j*COEF_W +: COEF_W] != 3'b100)
      else $error("coefficient out of -2..2");
  end

  // With the result side empty, a new request is always taken.
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");
`endif

endmodule
